// ===== sv/mcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared constants and types for the collinear point counter.
// ----------------------------------------------------------------------------
package mcp_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int RES_W          = 9;

    typedef logic [RES_W-1:0] t_result;

endpackage

// ===== sv/mcp_if.sv =====
// ----------------------------------------------------------------------------
// mcp_point_if, mcp_result_if
// Valid/ready channels for input points and for results.
// ----------------------------------------------------------------------------
interface mcp_point_if #(
    parameter int COORD_BITS = mcp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last;

    modport source (output valid, x_coord, y_coord, last, input ready);
    modport sink   (input valid, x_coord, y_coord, last, output ready);
endinterface

interface mcp_result_if;
    import mcp_pkg::*;
    logic    valid;
    logic    ready;
    t_result max_collinear;
    logic    overflow;

    modport source (output valid, max_collinear, overflow, input ready);
    modport sink   (input valid, max_collinear, overflow, output ready);
endinterface

// ===== sv/mcp_ram.sv =====
// ----------------------------------------------------------------------------
// mcp_ram
// Generic single-write, single-read memory with a registered read.
// ----------------------------------------------------------------------------
module mcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/mcp_cross_cmp.sv =====
// ----------------------------------------------------------------------------
// mcp_cross_cmp
// Compares two sign-normalized direction pairs by their cross products.
// ----------------------------------------------------------------------------
module mcp_cross_cmp #(
    parameter int SW = 17
) (
    input  logic                 i_clk,
    input  logic signed [SW-1:0] i_a_dx,
    input  logic signed [SW-1:0] i_a_dy,
    input  logic signed [SW-1:0] i_b_dx,
    input  logic signed [SW-1:0] i_b_dy,
    output logic                 o_equal
);
    logic signed [2*SW-1:0] r_prod_ab;
    logic signed [2*SW-1:0] r_prod_ba;

    always_ff @(posedge i_clk) begin
        r_prod_ab <= i_a_dx * i_b_dy;
        r_prod_ba <= i_b_dx * i_a_dy;
    end

    assign o_equal = (r_prod_ab == r_prod_ba);
endmodule

// ===== sv/max_collinear_points_top.sv =====
// ----------------------------------------------------------------------------
// max_collinear_points_top
// Largest number of loaded points that lie on one straight line.
// ----------------------------------------------------------------------------
// Points arrive on i_point, one transfer per cycle while the block is loading.
// The transfer with last set closes the set; up to MAX_POINTS points are kept
// and any further points are dropped and reported through overflow.
// After the last point the input is held off while the set is evaluated.
// For each anchor i, every later point has its direction formed in S_S_RD
// and S_S_CAL, and every pair of later points passes through the read, the
// cross multiply and the compare in S_K_RD, S_K_MUL and S_K_CMP; the pace
// is set by the single read port of the direction memory.
// Sets of two or fewer points go from the last transfer straight to S_FIN.
// One result per set appears on o_result and is held in an output register
// until it is taken; loading of the next set may begin meanwhile, and a
// further result waits until the register is free.
// Reset empties the set and clears any pending result.
// ----------------------------------------------------------------------------
module max_collinear_points_top #(
    parameter int MAX_POINTS = mcp_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mcp_pkg::COORD_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mcp_point_if.sink     i_point,
    mcp_result_if.source  o_result
);
    import mcp_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int SW    = COORD_BITS + 1;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_A_RD  = 4'd1;
    localparam logic [3:0] S_A_LAT = 4'd2;
    localparam logic [3:0] S_S_RD  = 4'd3;
    localparam logic [3:0] S_S_CAL = 4'd4;
    localparam logic [3:0] S_C_RD  = 4'd5;
    localparam logic [3:0] S_C_LAT = 4'd6;
    localparam logic [3:0] S_K_RD  = 4'd7;
    localparam logic [3:0] S_K_MUL = 4'd8;
    localparam logic [3:0] S_K_CMP = 4'd9;
    localparam logic [3:0] S_J_END = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_drop, n_drop;
    logic [CW-1:0]         r_best, n_best;
    logic [CW-1:0]         r_c, n_c;
    logic [AW-1:0]         r_i, n_i;
    logic [AW-1:0]         r_j, n_j;
    logic [AW-1:0]         r_k, n_k;
    logic signed [SW-1:0]  r_ax, n_ax;
    logic signed [SW-1:0]  r_ay, n_ay;
    logic signed [SW-1:0]  r_rdx, n_rdx;
    logic signed [SW-1:0]  r_rdy, n_rdy;
    logic                  r_res_valid, n_res_valid;
    t_result               r_res, n_res;
    logic                  r_res_ovf, n_res_ovf;

    logic                  pt_we;
    logic [AW-1:0]         pt_raddr;
    logic [2*COORD_BITS-1:0] pt_rdata;
    logic                  sl_we;
    logic [AW-1:0]         sl_raddr;
    logic [2*SW-1:0]       sl_wdata;
    logic [2*SW-1:0]       sl_rdata;
    logic [AW-1:0]         last_idx;
    logic signed [SW-1:0]  dx, dy, ndx, ndy;
    logic signed [SW-1:0]  cand_dx, cand_dy;
    logic                  slope_eq;
    logic                  accept;
    logic                  slot_free;

    assign accept    = i_point.valid && i_point.ready;
    assign slot_free = !r_res_valid || o_result.ready;
    assign last_idx  = AW'(r_cnt - CW'(1));
    assign pt_we     = accept && (r_cnt < CW'(MAX_POINTS));
    assign pt_raddr  = (r_state == S_A_RD) ? r_i : r_j;
    assign sl_raddr  = (r_state == S_C_RD) ? r_j : r_k;
    assign sl_we     = (r_state == S_S_CAL);
    assign sl_wdata  = {ndx, ndy};
    assign cand_dx   = sl_rdata[2*SW-1:SW];
    assign cand_dy   = sl_rdata[SW-1:0];

    assign dx = r_ax - SW'($signed(pt_rdata[2*COORD_BITS-1:COORD_BITS]));
    assign dy = r_ay - SW'($signed(pt_rdata[COORD_BITS-1:0]));

    always_comb begin
        if (dx == '0) begin
            ndx = '0;
            ndy = SW'(1);
        end else if (dy == '0) begin
            ndx = SW'(1);
            ndy = '0;
        end else if (dy < 0) begin
            ndx = -dx;
            ndy = -dy;
        end else begin
            ndx = dx;
            ndy = dy;
        end
    end

    mcp_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (AW'(r_cnt)),
        .i_wdata ({i_point.x_coord, i_point.y_coord}),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    mcp_ram #(.WIDTH(2*SW), .DEPTH(MAX_POINTS)) u_slope_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (r_j),
        .i_wdata (sl_wdata),
        .i_raddr (sl_raddr),
        .o_rdata (sl_rdata)
    );

    mcp_cross_cmp #(.SW(SW)) u_cross_cmp (
        .i_clk   (i_clk),
        .i_a_dx  (r_rdx),
        .i_a_dy  (r_rdy),
        .i_b_dx  (cand_dx),
        .i_b_dy  (cand_dy),
        .o_equal (slope_eq)
    );

    assign i_point.ready          = (r_state == S_LOAD);
    assign o_result.valid         = r_res_valid;
    assign o_result.max_collinear = r_res;
    assign o_result.overflow      = r_res_ovf;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_drop      = r_drop;
        n_best      = r_best;
        n_c         = r_c;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_rdx       = r_rdx;
        n_rdy       = r_rdy;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        n_res_ovf   = r_res_ovf;
        if (r_res_valid && o_result.ready) begin
            n_res_valid = 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_cnt < CW'(MAX_POINTS)) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_point.last) begin
                        n_i    = '0;
                        n_best = '0;
                        if (n_cnt <= CW'(2)) begin
                            n_best  = n_cnt;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_LAT;
            end
            S_A_LAT: begin
                n_ax    = SW'($signed(pt_rdata[2*COORD_BITS-1:COORD_BITS]));
                n_ay    = SW'($signed(pt_rdata[COORD_BITS-1:0]));
                n_j     = r_i + AW'(1);
                n_state = S_S_RD;
            end
            S_S_RD: begin
                n_state = S_S_CAL;
            end
            S_S_CAL: begin
                if (r_j == last_idx) begin
                    n_j     = r_i + AW'(1);
                    n_state = S_C_RD;
                end else begin
                    n_j     = r_j + AW'(1);
                    n_state = S_S_RD;
                end
            end
            S_C_RD: begin
                n_state = S_C_LAT;
            end
            S_C_LAT: begin
                n_rdx = cand_dx;
                n_rdy = cand_dy;
                n_c   = CW'(1);
                n_k   = r_j + AW'(1);
                if (r_j == last_idx) begin
                    n_state = S_J_END;
                end else begin
                    n_state = S_K_RD;
                end
            end
            S_K_RD: begin
                n_state = S_K_MUL;
            end
            S_K_MUL: begin
                n_state = S_K_CMP;
            end
            S_K_CMP: begin
                if (slope_eq) begin
                    n_c = r_c + CW'(1);
                end
                if (r_k == last_idx) begin
                    n_state = S_J_END;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_K_RD;
                end
            end
            S_J_END: begin
                if (r_c + CW'(1) > r_best) begin
                    n_best = r_c + CW'(1);
                end
                if (r_j == last_idx) begin
                    if (r_i + AW'(1) == last_idx) begin
                        n_state = S_FIN;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_A_RD;
                    end
                end else begin
                    n_j     = r_j + AW'(1);
                    n_state = S_C_RD;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_res_valid = 1'b1;
                    n_res       = RES_W'(r_best);
                    n_res_ovf   = r_drop;
                    n_cnt       = '0;
                    n_drop      = 1'b0;
                    n_best      = '0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_best      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_drop      <= n_drop;
            r_best      <= n_best;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c       <= n_c;
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_rdx     <= n_rdx;
        r_rdy     <= n_rdy;
        r_res     <= n_res;
        r_res_ovf <= n_res_ovf;
    end
endmodule
